>>> rtl/bgit_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bgit_pkg
// Shared widths, reset values, codes and types of the ball goal intercept
// tracker.
// ============================================================================
package bgit_pkg;

    // Field and register widths
    localparam int COORD_W = 12;
    localparam int REG_W   = 12;
    localparam int IDX_W   = 3;
    localparam int DIFF_W  = COORD_W + 1;

    // Datapath widths, sized for the largest lookahead gain (15)
    localparam int PX_W   = 18;   // predicted point and old-minus-predicted
    localparam int CAB_W  = 25;   // cross product of the goal line points
    localparam int COP_W  = 31;   // cross product of old and predicted point
    localparam int DET_W  = 32;   // determinant
    localparam int ACC_W  = 44;   // numerator, accumulator, quotient
    localparam int MA_W   = 32;   // multiplier operand a
    localparam int MB_W   = 18;   // multiplier operand b

    // Parameter defaults
    localparam int DEF_LOOKAHEAD_GAIN = 5;
    localparam int DEF_COORD_BITS     = 12;

    // Register reset values
    localparam logic [REG_W-1:0] RST_LINE_A_X      = 12'd85;
    localparam logic [REG_W-1:0] RST_LINE_A_Y      = 12'd760;
    localparam logic [REG_W-1:0] RST_LINE_B_X      = 12'd1167;
    localparam logic [REG_W-1:0] RST_LINE_B_Y      = 12'd709;
    localparam logic [REG_W-1:0] RST_WINDOW_LOW    = 12'd455;
    localparam logic [REG_W-1:0] RST_WINDOW_HIGH   = 12'd830;
    localparam logic [REG_W-1:0] RST_STILL_LIMIT   = 12'd3;
    localparam logic [REG_W-1:0] RST_MOVE_LIMIT    = 12'd20;

    // Crossing reported for a ball moving away from the goal
    localparam logic [ACC_W-1:0] AWAY_X = 44'd643;

    typedef enum logic [IDX_W-1:0] {
        REG_LINE_A_X    = 3'd0,
        REG_LINE_A_Y    = 3'd1,
        REG_LINE_B_X    = 3'd2,
        REG_LINE_B_Y    = 3'd3,
        REG_WINDOW_LOW  = 3'd4,
        REG_WINDOW_HIGH = 3'd5,
        REG_STILL_LIMIT = 3'd6,
        REG_MOVE_LIMIT  = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_CHECK,
        ST_CALC,
        ST_SOLVE,
        ST_DIV,
        ST_WINDOW,
        ST_EMIT
    } bgit_state_t;

    // Micro-operations of the shared multiply-add unit, in issue order
    typedef enum logic [3:0] {
        OP_DX,
        OP_DY,
        OP_PX,
        OP_PY,
        OP_ABX,
        OP_ABY,
        OP_OXPX,
        OP_OYPY,
        OP_DET_A,
        OP_DET,
        OP_CAB_A,
        OP_CAB,
        OP_COP_A,
        OP_COP,
        OP_NUM_A,
        OP_NUM
    } uop_t;

    // One multiply-add request: res = c + a*b, or c - a*b when neg is set
    typedef struct packed {
        logic signed [MA_W-1:0]  a;
        logic signed [MB_W-1:0]  b;
        logic signed [ACC_W-1:0] c;
        logic                    neg;
    } mac_op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/bgit_mac.sv
`timescale 1ns / 1ps
// ============================================================================
// bgit_mac
// Shared signed multiply-add unit; the caller registers the result.
// ============================================================================
module bgit_mac
    import bgit_pkg::*;
(
    input  mac_op_t                 op,
    output logic signed [ACC_W-1:0] res
);

    logic signed [MA_W+MB_W-1:0] prod;
    logic signed [ACC_W-1:0]     prod_lo;

    always_comb
    begin
        prod    = $signed(op.a) * $signed(op.b);
        prod_lo = prod[ACC_W-1:0];
        if (op.neg)
        begin
            res = op.c - prod_lo;
        end
        else
        begin
            res = op.c + prod_lo;
        end
    end

endmodule

>>> rtl/bgit_div.sv
`timescale 1ns / 1ps
// ============================================================================
// bgit_div
// Serial signed divider, one quotient bit per cycle, truncates toward zero.
// ============================================================================
module bgit_div
    import bgit_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic signed [DET_W-1:0] divisor,
    output div_stat_t               stat,
    output logic signed [ACC_W-1:0] quotient
);

    localparam int CNT_W = $clog2(ACC_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DET_W-1:0] rem_reg;
    logic [ACC_W-1:0] dvd_reg;
    logic [DET_W-1:0] dmag_reg;
    logic             neg_reg;

    logic [DET_W:0]   shifted;
    logic [DET_W:0]   trial;
    logic             fits;
    logic [DET_W-1:0] rem_next;
    logic [ACC_W-1:0] dvd_next;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[ACC_W-1]};
        trial    = shifted - {1'b0, dmag_reg};
        fits     = !trial[DET_W];
        rem_next = fits ? trial[DET_W-1:0] : shifted[DET_W-1:0];
        dvd_next = {dvd_reg[ACC_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ACC_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands go in as magnitudes; the sign is put back at the end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            dvd_reg  <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            dmag_reg <= divisor[DET_W-1] ? DET_W'(-divisor) : DET_W'(divisor);
            neg_reg  <= dividend[ACC_W-1] ^ divisor[DET_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);

endmodule

>>> rtl/ball_goal_intercept_tracker.sv
`timescale 1ns / 1ps
// ============================================================================
// ball_goal_intercept_tracker
// Predicts where a moving ball crosses the goal line and drives the keeper.
// ============================================================================
// Usage:
//   Ball centers come in on the center channel (center_valid / center_stall,
//   center_x, center_y). One center is taken at a time; center_stall stays
//   high while a center is being worked on.
//   Results leave on the crossing channel (crossing_valid / crossing_stall,
//   crossing_x, move_keeper) from an output register, so a new center is
//   taken while a result still waits for the receiver. A stalled result
//   holds; the block waits in its last step only if a second result is
//   ready before the first was taken. Registers are written over
//   cfg_valid / cfg_ready (always ready) with cfg_index and cfg_data. The
//   user must write them only while no center is in flight (not enforced).
// Paths:
//   A center of (0,0) is taken but not worked on. A ball standing still
//   ends at the check step, a ball moving away after the window check,
//   plus the emit step when a word is sent. A ball moving toward the goal
//   takes 16 multiply-add steps on one shared multiplier, then the
//   one-bit-per-cycle divider (44 quotient bits) that forms the crossing x.
//   A path parallel to the goal line skips the divider.
// Reset:
//   rst_n clears the last center and last crossing to zero, loads the
//   default goal line, window and limits, and empties the output register.
// ============================================================================
module ball_goal_intercept_tracker
    import bgit_pkg::*;
#(
    parameter int LOOKAHEAD_GAIN = DEF_LOOKAHEAD_GAIN,
    parameter int COORD_BITS     = DEF_COORD_BITS
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               center_valid,
    output logic               center_stall,
    input  logic [COORD_W-1:0] center_x,
    input  logic [COORD_W-1:0] center_y,
    output logic               crossing_valid,
    input  logic               crossing_stall,
    output logic [COORD_W-1:0] crossing_x,
    output logic               move_keeper,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [REG_W-1:0]   cfg_data
);

    localparam logic [COORD_W-1:0] CoordMask = COORD_W'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [MB_W-1:0]    GainOp    = MB_W'(LOOKAHEAD_GAIN);
    localparam logic [MB_W-1:0]    OneOp     = MB_W'(1);

    bgit_state_t state_reg, state_next;
    uop_t        step_reg, step_next;

    // Configuration
    logic [REG_W-1:0] line_a_x_reg, line_a_y_reg, line_b_x_reg, line_b_y_reg;
    logic [REG_W-1:0] window_low_reg, window_high_reg, still_limit_reg, move_limit_reg;

    // Tracking state
    logic [COORD_W-1:0] ox_reg, oy_reg;
    logic [COORD_W-1:0] last_crossing_reg;

    // Working values
    logic [COORD_W-1:0]       nx_reg, ny_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, abx_reg, aby_reg;
    logic signed [PX_W-1:0]   px_reg, py_reg, oxpx_reg, oypy_reg;
    logic signed [DET_W-1:0]  det_reg;
    logic signed [CAB_W-1:0]  cab_reg;
    logic signed [COP_W-1:0]  cop_reg;
    logic signed [ACC_W-1:0]  tmp_reg, num_reg, cx_reg;
    logic                     move_reg;

    // Output register
    logic               crossing_valid_reg;
    logic [COORD_W-1:0] crossing_x_reg;
    logic               move_keeper_reg;

    logic [COORD_W-1:0] ax, ay, bx, by;
    logic               accept;
    logic               center_zero;
    logic [DIFF_W-1:0]  adx, ady;
    logic               is_still;
    logic               toward;
    logic [ACC_W-1:0]   cx_u;
    logic               in_window;
    logic signed [DIFF_W-1:0] cross_diff;
    logic [DIFF_W-1:0]  cross_mag;
    logic               move_flag;
    logic               out_free;
    logic               det_zero;

    mac_op_t                 mac_op;
    logic signed [ACC_W-1:0] mac_res;
    logic                    div_start;
    div_stat_t               div_stat;
    logic signed [ACC_W-1:0] div_quo;

    bgit_mac u_mac (
        .op  (mac_op),
        .res (mac_res)
    );

    bgit_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (det_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb
    begin
        ax = line_a_x_reg & CoordMask;
        ay = line_a_y_reg & CoordMask;
        bx = line_b_x_reg & CoordMask;
        by = line_b_y_reg & CoordMask;

        accept      = center_valid && !center_stall;
        center_zero = ((center_x & CoordMask) == '0) && ((center_y & CoordMask) == '0);

        adx      = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
        ady      = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
        is_still = (adx < DIFF_W'(still_limit_reg)) || (ady < DIFF_W'(still_limit_reg));
        toward   = !dy_reg[DIFF_W-1];

        cx_u      = cx_reg;
        in_window = !cx_u[ACC_W-1] && (cx_u > ACC_W'(window_low_reg))
                    && (cx_u < ACC_W'(window_high_reg));

        cross_diff = $signed({1'b0, last_crossing_reg})
                     - $signed({1'b0, cx_u[COORD_W-1:0]});
        cross_mag  = cross_diff[DIFF_W-1] ? DIFF_W'(-cross_diff) : DIFF_W'(cross_diff);
        move_flag  = cross_mag > DIFF_W'(move_limit_reg);

        out_free = !crossing_valid_reg || !crossing_stall;
        det_zero = (det_reg == '0);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !center_zero)
                begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                step_next = uop_t'(4'(step_reg) + 4'd1);
                if (step_reg == OP_DY)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (is_still)
                begin
                    state_next = ST_IDLE;
                    step_next  = OP_DX;
                end
                else if (toward)
                begin
                    state_next = ST_CALC;
                end
                else
                begin
                    state_next = ST_WINDOW;
                    step_next  = OP_DX;
                end
            end
            ST_CALC:
            begin
                if (step_reg == OP_NUM)
                begin
                    state_next = ST_SOLVE;
                    step_next  = OP_DX;
                end
                else
                begin
                    step_next = uop_t'(4'(step_reg) + 4'd1);
                end
            end
            ST_SOLVE:
            begin
                state_next = det_zero ? ST_WINDOW : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_WINDOW;
                end
            end
            ST_WINDOW:
            begin
                state_next = in_window ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = OP_DX;
            end
        endcase
    end

    // Outputs of the sequencer: handshake, divider start, multiply-add request
    always_comb
    begin
        center_stall = (state_reg != ST_IDLE);
        div_start    = (state_reg == ST_SOLVE) && !det_zero;

        mac_op.a   = '0;
        mac_op.b   = '0;
        mac_op.c   = '0;
        mac_op.neg = 1'b0;
        case (step_reg)
            OP_DX:
            begin
                mac_op.c   = ACC_W'(nx_reg);
                mac_op.a   = MA_W'(ox_reg);
                mac_op.b   = OneOp;
                mac_op.neg = 1'b1;
            end
            OP_DY:
            begin
                mac_op.c   = ACC_W'(ny_reg);
                mac_op.a   = MA_W'(oy_reg);
                mac_op.b   = OneOp;
                mac_op.neg = 1'b1;
            end
            OP_PX:
            begin
                mac_op.c = ACC_W'(nx_reg);
                mac_op.a = MA_W'(dx_reg);
                mac_op.b = GainOp;
            end
            OP_PY:
            begin
                mac_op.c = ACC_W'(ny_reg);
                mac_op.a = MA_W'(dy_reg);
                mac_op.b = GainOp;
            end
            OP_ABX:
            begin
                mac_op.c   = ACC_W'(ax);
                mac_op.a   = MA_W'(bx);
                mac_op.b   = OneOp;
                mac_op.neg = 1'b1;
            end
            OP_ABY:
            begin
                mac_op.c   = ACC_W'(ay);
                mac_op.a   = MA_W'(by);
                mac_op.b   = OneOp;
                mac_op.neg = 1'b1;
            end
            OP_OXPX:
            begin
                mac_op.c   = ACC_W'(ox_reg);
                mac_op.a   = MA_W'(px_reg);
                mac_op.b   = OneOp;
                mac_op.neg = 1'b1;
            end
            OP_OYPY:
            begin
                mac_op.c   = ACC_W'(oy_reg);
                mac_op.a   = MA_W'(py_reg);
                mac_op.b   = OneOp;
                mac_op.neg = 1'b1;
            end
            OP_DET_A:
            begin
                mac_op.a = MA_W'(abx_reg);
                mac_op.b = MB_W'(oypy_reg);
            end
            OP_DET:
            begin
                mac_op.c   = tmp_reg;
                mac_op.a   = MA_W'(aby_reg);
                mac_op.b   = MB_W'(oxpx_reg);
                mac_op.neg = 1'b1;
            end
            OP_CAB_A:
            begin
                mac_op.a = MA_W'(ax);
                mac_op.b = MB_W'(by);
            end
            OP_CAB:
            begin
                mac_op.c   = tmp_reg;
                mac_op.a   = MA_W'(ay);
                mac_op.b   = MB_W'(bx);
                mac_op.neg = 1'b1;
            end
            OP_COP_A:
            begin
                mac_op.a = MA_W'(ox_reg);
                mac_op.b = MB_W'(py_reg);
            end
            OP_COP:
            begin
                mac_op.c   = tmp_reg;
                mac_op.a   = MA_W'(oy_reg);
                mac_op.b   = MB_W'(px_reg);
                mac_op.neg = 1'b1;
            end
            OP_NUM_A:
            begin
                mac_op.a = MA_W'(cab_reg);
                mac_op.b = MB_W'(oxpx_reg);
            end
            OP_NUM:
            begin
                mac_op.c   = tmp_reg;
                mac_op.a   = MA_W'(cop_reg);
                mac_op.b   = MB_W'(abx_reg);
                mac_op.neg = 1'b1;
            end
            default:
            begin
                mac_op.neg = 1'b0;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            step_reg           <= OP_DX;
            ox_reg             <= '0;
            oy_reg             <= '0;
            last_crossing_reg  <= '0;
            crossing_valid_reg <= 1'b0;
            line_a_x_reg       <= RST_LINE_A_X;
            line_a_y_reg       <= RST_LINE_A_Y;
            line_b_x_reg       <= RST_LINE_B_X;
            line_b_y_reg       <= RST_LINE_B_Y;
            window_low_reg     <= RST_WINDOW_LOW;
            window_high_reg    <= RST_WINDOW_HIGH;
            still_limit_reg    <= RST_STILL_LIMIT;
            move_limit_reg     <= RST_MOVE_LIMIT;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            // Store the new center when still, or once the crossing is known
            if ((state_reg == ST_CHECK && is_still) || state_reg == ST_WINDOW)
            begin
                ox_reg <= nx_reg;
                oy_reg <= ny_reg;
            end

            if (state_reg == ST_WINDOW && in_window)
            begin
                last_crossing_reg <= cx_u[COORD_W-1:0];
            end

            if (state_reg == ST_EMIT && out_free)
            begin
                crossing_valid_reg <= 1'b1;
            end
            else if (crossing_valid_reg && !crossing_stall)
            begin
                crossing_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_LINE_A_X:    line_a_x_reg    <= cfg_data;
                    REG_LINE_A_Y:    line_a_y_reg    <= cfg_data;
                    REG_LINE_B_X:    line_b_x_reg    <= cfg_data;
                    REG_LINE_B_Y:    line_b_y_reg    <= cfg_data;
                    REG_WINDOW_LOW:  window_low_reg  <= cfg_data;
                    REG_WINDOW_HIGH: window_high_reg <= cfg_data;
                    REG_STILL_LIMIT: still_limit_reg <= cfg_data;
                    REG_MOVE_LIMIT:  move_limit_reg  <= cfg_data;
                    default:         move_limit_reg  <= move_limit_reg;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            nx_reg <= center_x & CoordMask;
            ny_reg <= center_y & CoordMask;
        end

        if (state_reg == ST_DELTA || state_reg == ST_CALC)
        begin
            case (step_reg)
                OP_DX:    dx_reg   <= mac_res[DIFF_W-1:0];
                OP_DY:    dy_reg   <= mac_res[DIFF_W-1:0];
                OP_PX:    px_reg   <= mac_res[PX_W-1:0];
                OP_PY:    py_reg   <= mac_res[PX_W-1:0];
                OP_ABX:   abx_reg  <= mac_res[DIFF_W-1:0];
                OP_ABY:   aby_reg  <= mac_res[DIFF_W-1:0];
                OP_OXPX:  oxpx_reg <= mac_res[PX_W-1:0];
                OP_OYPY:  oypy_reg <= mac_res[PX_W-1:0];
                OP_DET:   det_reg  <= mac_res[DET_W-1:0];
                OP_CAB:   cab_reg  <= mac_res[CAB_W-1:0];
                OP_COP:   cop_reg  <= mac_res[COP_W-1:0];
                OP_NUM:   num_reg  <= mac_res;
                default:  tmp_reg  <= mac_res;
            endcase
        end

        if (state_reg == ST_CHECK && !is_still && !toward)
        begin
            cx_reg <= AWAY_X;
        end
        else if (state_reg == ST_SOLVE && det_zero)
        begin
            cx_reg <= '0;
        end
        else if (state_reg == ST_DIV && div_stat.done)
        begin
            cx_reg <= div_quo;
        end

        if (state_reg == ST_WINDOW)
        begin
            move_reg <= move_flag;
        end

        if (state_reg == ST_EMIT && out_free)
        begin
            crossing_x_reg  <= last_crossing_reg;
            move_keeper_reg <= move_reg;
        end
    end

    assign crossing_valid = crossing_valid_reg;
    assign crossing_x     = crossing_x_reg;
    assign move_keeper    = move_keeper_reg;
    assign cfg_ready      = 1'b1;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == ST_DIV)
        else $error("divider running outside the divide step");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy && !div_stat.done)
        else $error("divider restarted while in use");

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(crossing_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("output word loaded outside the emit step");

    a_step_home: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> step_reg == OP_DX)
        else $error("sequencer step not rewound when idle");

endmodule
